>>> rtl/core/wsfd_pkg.sv
// types and constants shared by the websocket frame deframer
`timescale 1ns / 1ps

package wsfd_pkg;

   // header byte counts for the three length forms
   localparam logic [3:0] HDR_LEN_SHORT = 4'd2;
   localparam logic [3:0] HDR_LEN_MID   = 4'd4;
   localparam logic [3:0] HDR_LEN_LONG  = 4'd10;

   // seven-bit length codes that announce an extended length
   localparam logic [6:0] LEN_CODE_MID  = 7'd126;
   localparam logic [6:0] LEN_CODE_LONG = 7'd127;

   // input transfer payload
   typedef struct packed {
      logic [7:0] data_byte;
   } req_type;

   // result transfer payload
   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       frame_start;
      logic       frame_end;
      logic       mask_error;
   } rsp_type;

   // commands to the length tracker
   typedef enum logic [2:0] {
      LEN_HOLD,
      LEN_CLEAR,
      LEN_LOAD_CODE,
      LEN_SHIFT,
      LEN_SHIFT_LOAD,
      LEN_COUNT
   } len_op_type;

   // status from the length tracker
   typedef struct packed {
      logic shifted_zero;
      logic remain_le1;
   } len_sts_type;

endpackage

>>> rtl/core/wsfd_req_if.sv
// input byte channel of the deframer
`timescale 1ns / 1ps

interface wsfd_req_if import wsfd_pkg::*; ();

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/wsfd_rsp_if.sv
// result channel of the deframer
`timescale 1ns / 1ps

interface wsfd_rsp_if import wsfd_pkg::*; ();

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/wsfd_len.sv
// frame length tracker: extended length accumulator and payload down counter
`timescale 1ns / 1ps

module wsfd_len import wsfd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  len_op_type  len_op,
   input  logic [7:0]  data_byte,
   output len_sts_type len_sts
);

   logic [LENGTH_BITS-1:0] acc_ff;
   logic [LENGTH_BITS-1:0] acc_in;
   logic [LENGTH_BITS-1:0] remain_ff;
   logic [LENGTH_BITS-1:0] remain_in;
   logic [LENGTH_BITS-1:0] shifted;

   // big-endian byte shifted in, high bits dropped
   assign shifted = {acc_ff[LENGTH_BITS-9:0], data_byte};

   assign len_sts.shifted_zero = (shifted == '0);
   assign len_sts.remain_le1   = (remain_ff[LENGTH_BITS-1:1] == '0);

   // next accumulator and remaining count
   always_comb begin
      acc_in    = acc_ff;
      remain_in = remain_ff;
      unique case (len_op)
         LEN_HOLD: begin
         end
         LEN_CLEAR: begin
            acc_in = '0;
         end
         LEN_LOAD_CODE: begin
            acc_in    = '0;
            remain_in = LENGTH_BITS'(data_byte[6:0]);
         end
         LEN_SHIFT: begin
            acc_in = shifted;
         end
         LEN_SHIFT_LOAD: begin
            acc_in    = '0;
            remain_in = shifted;
         end
         LEN_COUNT: begin
            remain_in = len_sts.remain_le1 ? '0 : (remain_ff - LENGTH_BITS'(1));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         remain_ff <= '0;
      end else begin
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> rtl/core/websocket_frame_deframer_core.sv
// Server-to-client WebSocket deframer: one stream byte per transfer in, one
// result per payload byte out. The block takes one byte every clock cycle
// unless result-side backpressure holds it. A taken byte waits in the input
// register and is decoded from it once the result slot is free; its result
// goes to the result register, which drives the output. The header decoder
// and the LENGTH_BITS-wide length counter finish each byte combinationally,
// so the rate is held only by backpressure on the result side. Header bytes
// give no result except for an empty frame (one result with start and end
// set) or a masked frame (one error result, after which all input is taken
// and dropped until reset). Lengths are kept to their low LENGTH_BITS bits.
`timescale 1ns / 1ps

module websocket_frame_deframer_core import wsfd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   wsfd_req_if.sink   req_ch,
   wsfd_rsp_if.source rsp_ch
);

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_EXT,
      PH_PAYLOAD
   } phase_type;

   // input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   // header state
   phase_type  phase_ff,   phase_in;
   logic [3:0] hdr_cnt_ff, hdr_cnt_in;
   logic       long_ff,    long_in;
   logic       fin_ff,     fin_in;
   logic [3:0] opcode_ff,  opcode_in;
   logic       first_ff,   first_in;
   logic       err_ff,     err_in;

   // result register
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_res_ff;
   rsp_type    res;
   logic       produce;

   logic        advance;
   logic [3:0]  hdr_total;
   len_op_type  len_op;
   len_sts_type len_sts;

   // one byte moves from the input register when the result slot is free
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;
   assign rsp_ch.valid = out_vld_ff;
   assign rsp_ch.data  = out_res_ff;

   assign hdr_total = long_ff ? HDR_LEN_LONG : HDR_LEN_MID;

   wsfd_len #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_len (
      .clock     (clock),
      .reset     (reset),
      .len_op    (len_op),
      .data_byte (in_byte_ff),
      .len_sts   (len_sts)
   );

   // header decode and payload marking
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      long_in    = long_ff;
      fin_in     = fin_ff;
      opcode_in  = opcode_ff;
      first_in   = first_ff;
      err_in     = err_ff;
      len_op     = LEN_HOLD;
      produce    = 1'b0;

      res.payload_byte = '0;
      res.has_byte     = 1'b0;
      res.opcode       = opcode_ff;
      res.fin          = fin_ff;
      res.frame_start  = 1'b0;
      res.frame_end    = 1'b0;
      res.mask_error   = 1'b0;

      if (advance && !err_ff) begin
         unique case (phase_ff)
            PH_FIRST: begin
               fin_in    = in_byte_ff[7];
               opcode_in = in_byte_ff[3:0];
               phase_in  = PH_SECOND;
            end
            PH_SECOND: begin
               if (in_byte_ff[7]) begin
                  // masked frame from the server side
                  err_in         = 1'b1;
                  produce        = 1'b1;
                  res.mask_error = 1'b1;
               end else if (in_byte_ff[6:0] == LEN_CODE_LONG ||
                            in_byte_ff[6:0] == LEN_CODE_MID) begin
                  long_in    = (in_byte_ff[6:0] == LEN_CODE_LONG);
                  hdr_cnt_in = HDR_LEN_SHORT;
                  phase_in   = PH_EXT;
                  len_op     = LEN_CLEAR;
               end else begin
                  long_in = 1'b0;
                  len_op  = LEN_LOAD_CODE;
                  if (in_byte_ff[6:0] == '0) begin
                     produce         = 1'b1;
                     res.frame_start = 1'b1;
                     res.frame_end   = 1'b1;
                     first_in        = 1'b0;
                     phase_in        = PH_FIRST;
                  end else begin
                     first_in = 1'b1;
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_EXT: begin
               if (hdr_cnt_ff + 4'd1 >= hdr_total) begin
                  len_op = LEN_SHIFT_LOAD;
                  if (len_sts.shifted_zero) begin
                     produce         = 1'b1;
                     res.frame_start = 1'b1;
                     res.frame_end   = 1'b1;
                     first_in        = 1'b0;
                     phase_in        = PH_FIRST;
                  end else begin
                     first_in = 1'b1;
                     phase_in = PH_PAYLOAD;
                  end
               end else begin
                  len_op     = LEN_SHIFT;
                  hdr_cnt_in = hdr_cnt_ff + 4'd1;
               end
            end
            PH_PAYLOAD: begin
               len_op           = LEN_COUNT;
               produce          = 1'b1;
               res.payload_byte = in_byte_ff;
               res.has_byte     = 1'b1;
               res.frame_start  = first_ff;
               res.frame_end    = len_sts.remain_le1;
               first_in         = 1'b0;
               if (len_sts.remain_le1) begin
                  phase_in = PH_FIRST;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // result slot fills on a producing byte and empties on a transfer
   always_comb begin
      if (advance && produce) begin
         out_vld_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_vld_in = 1'b0;
      end else begin
         out_vld_in = out_vld_ff;
      end
   end

   // state, input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_FIRST;
         hdr_cnt_ff <= '0;
         long_ff    <= 1'b0;
         fin_ff     <= 1'b0;
         opcode_ff  <= '0;
         first_ff   <= 1'b0;
         err_ff     <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            in_vld_ff <= req_ch.valid;
         end
         out_vld_ff <= out_vld_in;
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         long_ff    <= long_in;
         fin_ff     <= fin_in;
         opcode_ff  <= opcode_in;
         first_ff   <= first_in;
         err_ff     <= err_in;
      end
      if (req_ch.ready && req_ch.valid) begin
         in_byte_ff <= req_ch.data.data_byte;
      end
      if (advance && produce) begin
         out_res_ff <= res;
      end
   end

`ifndef SYNTHESIS
   // after a mask error no new result is ever produced
   a_silent_after_error: assert property (@(posedge clock) disable iff (reset)
      (err_ff && !out_vld_ff) |=> !out_vld_ff)
      else $error("result produced after mask error");

   // a held byte waits in the input register unchanged
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_byte_ff)))
      else $error("input register lost a stalled byte");

   // the last payload byte of a frame returns to the first header byte
   a_frame_end_phase: assert property (@(posedge clock) disable iff (reset)
      (advance && !err_ff && phase_ff == PH_PAYLOAD && len_sts.remain_le1)
      |=> (phase_ff == PH_FIRST))
      else $error("frame end did not return to header");

   // an error result only comes from the second header byte
   a_error_source: assert property (@(posedge clock) disable iff (reset)
      (advance && produce && res.mask_error) |-> (phase_ff == PH_SECOND))
      else $error("mask error outside second header byte");
`endif

endmodule

>>> tb/sv/wsfd_frame_checker.sv
// predictor and result checker for the websocket frame deframer
`timescale 1ns / 1ps

module wsfd_frame_checker import wsfd_pkg::*; #(
   parameter int LENGTH_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   wsfd_req_if  req_mon,
   wsfd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   checked_count
);

   // header phases of the deframer
   localparam logic [3:0] PH_FIRST   = 4'd0;
   localparam logic [3:0] PH_SECOND  = 4'd1;
   localparam logic [3:0] PH_PAYLOAD = 4'd15;

   // length forms announced by the second header byte
   localparam logic [1:0] KIND_SHORT = 2'd0;
   localparam logic [1:0] KIND_MID   = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;

   // predicted deframer state
   logic [3:0]             hdr_phase;
   logic [7:0]             hdr_byte0;
   logic [1:0]             len_kind;
   logic [LENGTH_BITS-1:0] len_acc;
   logic [LENGTH_BITS-1:0] bytes_left;
   logic                   first_pending;
   logic                   err_latched;

   // results still owed by the block, oldest first
   rsp_type expected_rsp_q[$];
   int      fails;
   int      checks;

   function automatic string rsp_text(rsp_type r);
      return $sformatf("byte %02h has %0b op %h fin %0b start %0b end %0b err %0b",
                       r.payload_byte, r.has_byte, r.opcode, r.fin,
                       r.frame_start, r.frame_end, r.mask_error);
   endfunction

   // header done: arm the payload, or flag an empty frame
   function automatic bit begin_payload(input logic [LENGTH_BITS-1:0] len,
                                        inout rsp_type res);
      bytes_left = len;
      len_acc    = '0;
      if (len == '0) begin
         hdr_phase       = PH_FIRST;
         first_pending   = 1'b0;
         res.frame_start = 1'b1;
         res.frame_end   = 1'b1;
         return 1'b1;
      end
      first_pending = 1'b1;
      hdr_phase     = PH_PAYLOAD;
      return 1'b0;
   endfunction

   // advance the predicted state by one stream byte
   function automatic bit deframe_byte(input logic [7:0] b, output rsp_type res);
      logic [3:0] hdr_total;
      logic       last;
      bit         emit;
      res  = '0;
      emit = 1'b0;
      if (err_latched)
         return 1'b0;
      case (hdr_phase)
         PH_FIRST: begin
            hdr_byte0 = b;
            hdr_phase = PH_SECOND;
         end
         PH_SECOND: begin
            len_acc = '0;
            if (b[7]) begin
               // masked server frame: one error result, then silence
               err_latched    = 1'b1;
               res.mask_error = 1'b1;
               emit           = 1'b1;
            end else if (b[6:0] == LEN_CODE_LONG) begin
               len_kind  = KIND_LONG;
               hdr_phase = HDR_LEN_SHORT;
            end else if (b[6:0] == LEN_CODE_MID) begin
               len_kind  = KIND_MID;
               hdr_phase = HDR_LEN_SHORT;
            end else begin
               len_kind = KIND_SHORT;
               emit     = begin_payload(LENGTH_BITS'(b[6:0]), res);
            end
         end
         PH_PAYLOAD: begin
            last            = (bytes_left <= 1);
            res.payload_byte = b;
            res.has_byte    = 1'b1;
            res.frame_start = first_pending;
            res.frame_end   = last;
            first_pending   = 1'b0;
            bytes_left      = last ? '0 : bytes_left - 1'b1;
            if (last)
               hdr_phase = PH_FIRST;
            emit = 1'b1;
         end
         default: begin
            // extended length, most significant byte first
            len_acc   = {len_acc[LENGTH_BITS-9:0], b};
            hdr_total = (len_kind == KIND_MID) ? HDR_LEN_MID : HDR_LEN_LONG;
            if (int'(hdr_phase) + 1 >= int'(hdr_total))
               emit = begin_payload(len_acc, res);
            else
               hdr_phase = hdr_phase + 4'd1;
         end
      endcase
      res.opcode = hdr_byte0[3:0];
      res.fin    = hdr_byte0[7];
      return emit;
   endfunction

   // watch both channels, predict on each byte transfer, check each result transfer
   always @(posedge clock) begin
      rsp_type pred_r;
      rsp_type exp_r;
      rsp_type got_r;
      if (reset) begin
         hdr_phase     = PH_FIRST;
         hdr_byte0     = '0;
         len_kind      = KIND_SHORT;
         len_acc       = '0;
         bytes_left    = '0;
         first_pending = 1'b0;
         err_latched   = 1'b0;
         expected_rsp_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (deframe_byte(req_mon.data.data_byte, pred_r))
               expected_rsp_q.push_back(pred_r);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_r = rsp_mon.data;
            if (expected_rsp_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected result: expected none, actual %s",
                        $realtime, rsp_text(got_r));
            end else begin
               exp_r = expected_rsp_q.pop_front();
               checks++;
               if (got_r !== exp_r) begin
                  fails++;
                  $display("%0t: result mismatch: expected %s", $realtime, rsp_text(exp_r));
                  $display("%0t:                  actual   %s", $realtime, rsp_text(got_r));
               end
            end
         end
      end
      fail_count    <= fails;
      checked_count <= checks;
      pending_count <= expected_rsp_q.size();
   end

endmodule

>>> tb/sv/tb_websocket_frame_deframer_core.sv
// top of the websocket frame deframer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_core;
   import wsfd_pkg::*;

   // length forms used when building headers
   localparam logic [1:0] KIND_SHORT = 2'd0;
   localparam logic [1:0] KIND_MID   = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;

   localparam int RANDOM_BYTES = 450;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 38;
   int recv_idle_pct = 84;
   int fail_count;
   int pending_count;
   int checked_count;
   int bytes_sent;
   int frames_sent;
   int empty_frames;
   int mid_frames;
   int long_frames;

   wsfd_req_if req_ch ();
   wsfd_rsp_if rsp_ch ();

   websocket_frame_deframer_core #(.LENGTH_BITS(32)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   wsfd_frame_checker #(.LENGTH_BITS(32)) frame_chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   always #6 clock = ~clock;

   // result side backpressure
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // one byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data.data_byte <= b;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      bytes_sent++;
   endtask

   // frame header in one of the three length forms
   task automatic send_header(input logic [7:0] hdr0, input logic [1:0] kind,
                              input logic [63:0] len);
      send_byte(hdr0);
      frames_sent++;
      case (kind)
         KIND_SHORT: begin
            send_byte({1'b0, len[6:0]});
         end
         KIND_MID: begin
            mid_frames++;
            send_byte({1'b0, LEN_CODE_MID});
            send_byte(len[15:8]);
            send_byte(len[7:0]);
         end
         default: begin
            long_frames++;
            send_byte({1'b0, LEN_CODE_LONG});
            for (int i = 7; i >= 0; i--)
               send_byte(len[i*8 +: 8]);
         end
      endcase
   endtask

   // random frame, mostly short payloads, any header bits
   task automatic send_random_frame();
      logic [7:0]  hdr0;
      logic [1:0]  kind;
      logic [63:0] len;
      int          sel;
      int          n;
      hdr0 = 8'($urandom_range(255));
      sel  = $urandom_range(99);
      if (sel < 55) begin
         kind = KIND_SHORT;
         if ($urandom_range(19) == 0)
            n = 125;
         else if ($urandom_range(9) == 0)
            n = $urandom_range(125);
         else
            n = $urandom_range(6);
         len = 64'(n);
      end else if (sel < 80) begin
         kind = KIND_MID;
         n    = ($urandom_range(7) == 0) ? $urandom_range(300, 256) : $urandom_range(8);
         len  = 64'(n);
      end else begin
         // upper half of a 64-bit length is dropped by the block
         kind = KIND_LONG;
         n    = $urandom_range(8);
         len  = {32'($urandom()), 32'(n)};
      end
      if (n == 0)
         empty_frames++;
      send_header(hdr0, kind, len);
      repeat (n)
         send_byte(8'($urandom_range(255)));
   endtask

   // bound on the whole run
   initial begin
      #5_000_000;
      $display("tb_websocket_frame_deframer_core failed");
      $finish;
   end

   // stimulus and verdict
   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty frame with fin set
      send_header(8'h81, KIND_SHORT, 64'd0);
      empty_frames++;
      // reserved bits set, continuation opcode, payload extremes
      send_header(8'h70, KIND_SHORT, 64'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      // 16-bit length, reserved opcode
      send_header(8'h0F, KIND_MID, 64'd2);
      send_byte(8'hA5);
      send_byte(8'h5A);
      // 64-bit length with a nonzero upper half
      send_header(8'h8A, KIND_LONG, 64'h1234_5678_0000_0001);
      send_byte(8'h3C);

      // random frames under the three idle patterns
      while (bytes_sent < RANDOM_BYTES) begin
         if (bytes_sent < RANDOM_BYTES / 3) begin
            send_idle_pct = 38;
            recv_idle_pct = 84;
         end else if (bytes_sent < 2 * RANDOM_BYTES / 3) begin
            send_idle_pct = 84;
            recv_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_frame();
      end

      // masked frame last, since the block stays silent until reset
      send_byte(8'h82);
      send_byte(8'hFE);
      frames_sent++;
      send_header(8'h81, KIND_SHORT, 64'd3);
      repeat (3)
         send_byte(8'($urandom_range(255)));
      req_ch.valid <= 1'b0;

      // drain outstanding results, then a short quiet period
      while (pending_count != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("sent %0d bytes in %0d frames (%0d empty, %0d 16-bit, %0d 64-bit lengths)",
               bytes_sent, frames_sent, empty_frames, mid_frames, long_frames);
      $display("checked %0d results, run closed by a masked frame and dropped input",
               checked_count);
      if (fail_count == 0)
         $display("tb_websocket_frame_deframer_core passed");
      else
         $display("tb_websocket_frame_deframer_core failed");
      $finish;
   end

endmodule
